@@ design/tmr_pkg.sv @@
// Shared types and constants of the tile map renderer.
package tmr_pkg;
   localparam int MapCells     = 65536;
   localparam int GroupEntries = 4096;
   localparam int Megatiles    = 8192;
   localparam int Tiles        = 32768;
   localparam int MapAw        = $clog2(MapCells);
   localparam int GroupAw      = $clog2(GroupEntries);
   localparam int SubAw        = $clog2(Megatiles * 16);
   localparam int TileAw       = $clog2(Tiles * 64);
   localparam int PalAw        = 8;
   localparam int QueueDepth   = 4;
   localparam int QueueAw      = $clog2(QueueDepth);

   typedef enum logic [2:0] {
      OP_MAP    = 3'd0,
      OP_GROUP  = 3'd1,
      OP_SUB    = 3'd2,
      OP_TILE   = 3'd3,
      OP_PAL    = 3'd4,
      OP_RENDER = 3'd5,
      OP_AVG    = 3'd6,
      OP_NONE   = 3'd7
   } op_type;

   localparam logic [1:0] CSR_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_BLOCK  = 2'd2;

   typedef struct packed {
      op_type      op;
      logic [20:0] addr;
      logic [23:0] data;
      logic [9:0]  sx;
      logic [9:0]  sy;
   } cmd_type;
endpackage

@@ design/tmr_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
module tmr_ram #(
   parameter int Width = 8,
   parameter int Depth = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

@@ design/tmr_front.sv @@
// Front end: takes command words and queues the ones that do work.
module tmr_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  logic [2:0]       req_operation,
   input  logic [20:0]      req_table_address,
   input  logic [23:0]      req_table_data,
   input  logic [9:0]       req_sub_x,
   input  logic [9:0]       req_sub_y,
   input  logic             pop,
   output logic             cmd_valid,
   output tmr_pkg::cmd_type cmd
);
   tmr_pkg::cmd_type q_ff [tmr_pkg::QueueDepth];
   logic [tmr_pkg::QueueAw-1:0] wp_ff, rp_ff;
   logic [tmr_pkg::QueueAw:0]   cnt_ff;
   logic push;

   assign busy      = (cnt_ff == (tmr_pkg::QueueAw+1)'(tmr_pkg::QueueDepth));
   // drop unused codes here
   assign push      = start && !busy &&
                      (tmr_pkg::op_type'(req_operation) != tmr_pkg::OP_NONE);
   assign cmd_valid = (cnt_ff != '0);
   assign cmd       = q_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) begin
            q_ff[wp_ff] <= '{op: tmr_pkg::op_type'(req_operation),
                            addr: req_table_address, data: req_table_data,
                            sx: req_sub_x, sy: req_sub_y};
            wp_ff <= wp_ff + 1'b1;
         end
         if (pop) begin
            rp_ff <= rp_ff + 1'b1;
         end
         cnt_ff <= cnt_ff + (tmr_pkg::QueueAw+1)'(push) - (tmr_pkg::QueueAw+1)'(pop);
      end
   end
endmodule

@@ design/tmr_back.sv @@
// Back end: table stores, lookup sequencer, averaging and divider.
module tmr_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   input  tmr_pkg::cmd_type cmd,
   output logic             pop,
   input  logic [8:0]       width_tiles,
   input  logic [5:0]       block_n,
   output logic             rsp_valid,
   output logic [23:0]      rsp_pixel_color,
   output logic             rsp_last
);
   typedef enum logic [3:0] {
      S_IDLE, S_CELL, S_GRP, S_MT, S_CODE, S_TILE, S_PAL, S_WAIT, S_DIV, S_OUT
   } state_type;

   state_type   state_ff;
   tmr_pkg::cmd_type c_ff;
   logic [5:0]  n_ff, it_ff, jt_ff;
   logic [6:0]  m_ff;        // byte counter, issue side
   logic [6:0]  got_ff;      // wait-state counter while the last reads drain
   logic        mirror_ff;
   logic [14:0] tile_ff;
   logic [15:0] cell_ff;
   logic [10:0] x_ff, y_ff;
   logic [29:0] rs_ff, gs_ff, bs_ff;
   logic [29:0] rq_ff, gq_ff, bq_ff;
   logic [29:0] rr_ff, gr_ff, br_ff;
   logic [4:0]  dbit_ff;
   logic [17:0] div_ff;
   logic        pv1_ff, pv2_ff, pl1_ff, pl2_ff;
   logic        ov_ff, ol_ff;
   logic [23:0] oc_ff;
   logic [25:0] prod;

   logic [15:0] map_q, grp_q, sub_q;
   logic [7:0]  tile_q;
   logic [23:0] pal_q;
   logic        wmap, wgrp, wsub, wtile, wpal, is_load;
   logic [tmr_pkg::MapAw-1:0]   map_ra;
   logic [tmr_pkg::GroupAw-1:0] grp_ra;
   logic [tmr_pkg::SubAw-1:0]   sub_ra;
   logic [tmr_pkg::TileAw-1:0]  tile_ra;
   logic [2:0]  col;
   logic [29:0] rt, gt, bt;

   assign is_load = (state_ff == S_IDLE) && cmd_valid &&
                    (cmd.op != tmr_pkg::OP_RENDER) && (cmd.op != tmr_pkg::OP_AVG);
   assign wmap  = is_load && cmd.op == tmr_pkg::OP_MAP &&
                  cmd.addr < 21'(tmr_pkg::MapCells);
   assign wgrp  = is_load && cmd.op == tmr_pkg::OP_GROUP &&
                  cmd.addr < 21'(tmr_pkg::GroupEntries);
   assign wsub  = is_load && cmd.op == tmr_pkg::OP_SUB &&
                  22'(cmd.addr) < 22'(tmr_pkg::Megatiles * 16);
   assign wtile = is_load && cmd.op == tmr_pkg::OP_TILE &&
                  22'(cmd.addr) < 22'(tmr_pkg::Tiles * 64);
   assign wpal  = is_load && cmd.op == tmr_pkg::OP_PAL && cmd.addr < 21'd256;
   assign pop   = is_load || (state_ff == S_OUT);

   assign prod   = 26'(y_ff[10:2]) * 26'(width_tiles) + 26'(x_ff[10:2]);
   assign map_ra = cell_ff[tmr_pkg::MapAw-1:0];
   assign grp_ra = map_q[tmr_pkg::GroupAw-1:0];
   assign sub_ra = {grp_q[$clog2(tmr_pkg::Megatiles)-1:0], x_ff[1:0], y_ff[1:0]};
   assign col    = (mirror_ff && c_ff.op == tmr_pkg::OP_RENDER) ? ~m_ff[2:0] : m_ff[2:0];
   assign tile_ra = {tile_ff[$clog2(tmr_pkg::Tiles)-1:0], m_ff[5:3], col};

   tmr_ram #(.Width(16), .Depth(tmr_pkg::MapCells)) u_map (
      .clock, .wr_en(wmap), .wr_addr(cmd.addr[tmr_pkg::MapAw-1:0]),
      .wr_data(cmd.data[15:0]), .rd_addr(map_ra), .rd_data(map_q));
   tmr_ram #(.Width(16), .Depth(tmr_pkg::GroupEntries)) u_grp (
      .clock, .wr_en(wgrp), .wr_addr(cmd.addr[tmr_pkg::GroupAw-1:0]),
      .wr_data(cmd.data[15:0]), .rd_addr(grp_ra), .rd_data(grp_q));
   tmr_ram #(.Width(16), .Depth(tmr_pkg::Megatiles * 16)) u_sub (
      .clock, .wr_en(wsub), .wr_addr(cmd.addr[tmr_pkg::SubAw-1:0]),
      .wr_data(cmd.data[15:0]), .rd_addr(sub_ra), .rd_data(sub_q));
   tmr_ram #(.Width(8), .Depth(tmr_pkg::Tiles * 64)) u_tile (
      .clock, .wr_en(wtile), .wr_addr(cmd.addr[tmr_pkg::TileAw-1:0]),
      .wr_data(cmd.data[7:0]), .rd_addr(tile_ra), .rd_data(tile_q));
   tmr_ram #(.Width(24), .Depth(256)) u_pal (
      .clock, .wr_en(wpal), .wr_addr(cmd.addr[tmr_pkg::PalAw-1:0]),
      .wr_data(cmd.data), .rd_addr(tile_q), .rd_data(pal_q));

   // restoring division step, one quotient bit per cycle
   assign rt = {rr_ff[28:0], rq_ff[29]};
   assign gt = {gr_ff[28:0], gq_ff[29]};
   assign bt = {br_ff[28:0], bq_ff[29]};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pv1_ff   <= 1'b0;
         pv2_ff   <= 1'b0;
         ov_ff    <= 1'b0;
      end else begin
         // palette read pipe: tile byte then palette word
         pv1_ff <= (state_ff == S_PAL) && (m_ff != 7'd64);
         pl1_ff <= (m_ff == 7'd63);
         pv2_ff <= pv1_ff;
         pl2_ff <= pl1_ff;
         ov_ff  <= (pv2_ff && c_ff.op == tmr_pkg::OP_RENDER) ||
                   (state_ff == S_OUT && c_ff.op == tmr_pkg::OP_AVG);
         if (pv2_ff) begin
            if (c_ff.op == tmr_pkg::OP_RENDER) begin
               oc_ff <= pal_q;
               ol_ff <= pl2_ff;
            end else begin
               rs_ff <= rs_ff + 30'(pal_q[23:16]);
               gs_ff <= gs_ff + 30'(pal_q[15:8]);
               bs_ff <= bs_ff + 30'(pal_q[7:0]);
            end
         end
         case (state_ff)
            S_IDLE: begin
               if (cmd_valid && !is_load) begin
                  c_ff  <= cmd;
                  n_ff  <= (block_n == 6'd0) ? 6'd1 : block_n;
                  it_ff <= '0;
                  jt_ff <= '0;
                  x_ff  <= {1'b0, cmd.sx};
                  y_ff  <= {1'b0, cmd.sy};
                  rs_ff <= '0;
                  gs_ff <= '0;
                  bs_ff <= '0;
                  state_ff <= S_CELL;
               end
            end
            S_CELL: begin
               cell_ff  <= prod[15:0];
               state_ff <= S_GRP;
            end
            S_GRP:  state_ff <= S_MT;
            S_MT:   state_ff <= S_CODE;
            S_CODE: state_ff <= S_TILE;
            S_TILE: begin
               tile_ff   <= sub_q[15:1];
               mirror_ff <= sub_q[0];
               m_ff      <= '0;
               state_ff  <= S_PAL;
            end
            S_PAL: begin
               if (m_ff != 7'd64) begin
                  m_ff <= m_ff + 7'd1;
               end else begin
                  state_ff <= S_WAIT;
                  got_ff   <= '0;
               end
            end
            S_WAIT: begin
               // let the last reads drain into the output or the sum
               got_ff <= got_ff + 7'd1;
               if (got_ff == 7'd2) begin
                  if (c_ff.op == tmr_pkg::OP_RENDER) begin
                     state_ff <= S_OUT;
                  end else if (jt_ff + 6'd1 != n_ff) begin
                     jt_ff <= jt_ff + 6'd1;
                     x_ff  <= x_ff + 11'd1;
                     state_ff <= S_CELL;
                  end else if (it_ff + 6'd1 != n_ff) begin
                     jt_ff <= '0;
                     it_ff <= it_ff + 6'd1;
                     x_ff  <= {1'b0, c_ff.sx};
                     y_ff  <= y_ff + 11'd1;
                     state_ff <= S_CELL;
                  end else begin
                     div_ff  <= 18'(n_ff) * 18'(n_ff) * 18'd64;
                     rq_ff   <= rs_ff;
                     gq_ff   <= gs_ff;
                     bq_ff   <= bs_ff;
                     rr_ff   <= '0;
                     gr_ff   <= '0;
                     br_ff   <= '0;
                     dbit_ff <= '0;
                     state_ff <= S_DIV;
                  end
               end
            end
            S_DIV: begin
               rr_ff <= (rt >= 30'(div_ff)) ? rt - 30'(div_ff) : rt;
               gr_ff <= (gt >= 30'(div_ff)) ? gt - 30'(div_ff) : gt;
               br_ff <= (bt >= 30'(div_ff)) ? bt - 30'(div_ff) : bt;
               rq_ff <= {rq_ff[28:0], rt >= 30'(div_ff)};
               gq_ff <= {gq_ff[28:0], gt >= 30'(div_ff)};
               bq_ff <= {bq_ff[28:0], bt >= 30'(div_ff)};
               dbit_ff <= dbit_ff + 5'd1;
               if (dbit_ff == 5'd29) begin
                  state_ff <= S_OUT;
               end
            end
            S_OUT: begin
               if (c_ff.op == tmr_pkg::OP_AVG) begin
                  ol_ff <= 1'b1;
                  oc_ff <= {rq_ff[7:0], gq_ff[7:0], bq_ff[7:0]};
               end
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid       = ov_ff;
   assign rsp_pixel_color = oc_ff;
   assign rsp_last        = ol_ff;
endmodule

@@ design/tile_map_renderer.sv @@
// Top level of the tile map renderer.
// Usage:
//   Command words enter on start/busy with req_operation, req_table_address,
//   req_table_data, req_sub_x and req_sub_y; a word is taken when start is
//   high and busy low. A four-word queue parts the front from the back end.
//   Load words write one table entry if the address is in range and return
//   nothing; they retire as soon as the back end is idle. A render returns
//   64 pixels, one per cycle, on rsp_valid with rsp_pixel_color and
//   rsp_last; the next word waits for it, its time set by the five-step
//   lookup and the single tile-byte read port. An averaged request walks
//   block_factor squared subtiles, runs the bit-serial divider and returns
//   one pixel. Registers are to be written on csr_valid/csr_ready only
//   while idle, which binds the user; the block does not enforce it.
//   csr_ready is always high. Synchronous reset empties the queue and sets
//   width 64, height 64, block factor 1 but does not clear the tables.
//   Results last one cycle; the receiver cannot stall.
module tile_map_renderer (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_operation,
   input  logic [20:0] req_table_address,
   input  logic [23:0] req_table_data,
   input  logic [9:0]  req_sub_x,
   input  logic [9:0]  req_sub_y,
   output logic        rsp_valid,
   output logic [23:0] rsp_pixel_color,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [8:0]  csr_data
);
   logic [8:0] width_ff, height_ff;
   logic [5:0] block_ff;
   logic       cmd_valid, pop;
   tmr_pkg::cmd_type cmd;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 9'd64;
         height_ff <= 9'd64;
         block_ff  <= 6'd1;
      end else if (csr_valid) begin
         case (csr_index)
            tmr_pkg::CSR_WIDTH:  width_ff  <= csr_data;
            tmr_pkg::CSR_HEIGHT: height_ff <= csr_data;
            tmr_pkg::CSR_BLOCK:  block_ff  <= csr_data[5:0];
            default: ;
         endcase
      end
   end

   // height is held for software only
   logic unused_height;
   assign unused_height = ^height_ff;

   tmr_front u_front (
      .clock, .reset, .start, .busy, .req_operation, .req_table_address,
      .req_table_data, .req_sub_x, .req_sub_y, .pop, .cmd_valid, .cmd);

   tmr_back u_back (
      .clock, .reset, .cmd_valid, .cmd, .pop, .width_tiles(width_ff),
      .block_n(block_ff), .rsp_valid, .rsp_pixel_color, .rsp_last);
endmodule

@@ dv/tb_top.sv @@
// Self-checking testbench of the tile map renderer: loads, renders and averaged pixels.
`timescale 1ns / 100ps

module tb_top;
   localparam logic [1:0] CsrSpare = 2'd3;
   localparam int CycleLimit = 3000000;

   typedef struct {
      logic [23:0] color;
      logic        last;
   } pixel_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [2:0]  req_operation = '0;
   logic [20:0] req_table_address = '0;
   logic [23:0] req_table_data = '0;
   logic [9:0]  req_sub_x = '0;
   logic [9:0]  req_sub_y = '0;
   logic        rsp_valid;
   logic [23:0] rsp_pixel_color;
   logic        rsp_last;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [8:0]  csr_data = '0;

   tile_map_renderer uut (.*);

   always #5 clock = ~clock;

   // predictor copy of the stores and registers
   logic [15:0] map_m [int unsigned];
   logic [15:0] grp_m [int unsigned];
   logic [15:0] sub_m [int unsigned];
   logic [7:0]  tile_m [int unsigned];
   logic [23:0] pal_m [int unsigned];
   bit          tile_pool [int unsigned];
   int unsigned width_cfg = 64, height_cfg = 64, block_cfg = 1;

   pixel_type pixels_due [$];
   int     errors = 0;
   int     cycles = 0;
   bit     idle_on = 1'b1;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("tb_top failed");
         $finish;
      end
   end

   // results are stable over the second half of their cycle
   always @(negedge clock) begin
      if (!reset && rsp_valid) begin
         pixel_type want;
         if (pixels_due.size() == 0) begin
            $error("unexpected pixel %h last %b", rsp_pixel_color, rsp_last);
            errors++;
         end else begin
            want = pixels_due.pop_front();
            if (rsp_pixel_color !== want.color) begin
               $error("pixel_color expected %h actual %h", want.color, rsp_pixel_color);
               errors++;
            end
            if (rsp_last !== want.last) begin
               $error("last expected %b actual %b", want.last, rsp_last);
               errors++;
            end
         end
      end
   end

   function automatic int unsigned cell_of(int unsigned x, int unsigned y);
      return ((y >> 2) * width_cfg + (x >> 2)) % tmr_pkg::MapCells;
   endfunction

   function automatic int unsigned sub_addr_of(int unsigned x, int unsigned y);
      int unsigned g, mt;
      g  = map_m[cell_of(x, y)] % tmr_pkg::GroupEntries;
      mt = grp_m[g] % tmr_pkg::Megatiles;
      return mt * 16 + (x & 3) * 4 + (y & 3);
   endfunction

   function automatic int unsigned tile_of(int unsigned x, int unsigned y);
      return ((sub_m[sub_addr_of(x, y)] >> 1) % tmr_pkg::Tiles) * 64;
   endfunction

   function automatic void predict(tmr_pkg::op_type op, logic [20:0] a, logic [23:0] d,
                                   logic [9:0] sx, logic [9:0] sy);
      pixel_type   p;
      int unsigned base, code, col, n, rs, gs, bs;
      logic [23:0] c;
      case (op)
         tmr_pkg::OP_MAP:   if (a < tmr_pkg::MapCells) map_m[a] = d[15:0];
         tmr_pkg::OP_GROUP: if (a < tmr_pkg::GroupEntries) grp_m[a] = d[15:0];
         tmr_pkg::OP_SUB:   if (a < tmr_pkg::Megatiles * 16) sub_m[a] = d[15:0];
         tmr_pkg::OP_TILE:  if (a < tmr_pkg::Tiles * 64) tile_m[a] = d[7:0];
         tmr_pkg::OP_PAL:   if (a < 256) pal_m[a] = d;
         tmr_pkg::OP_RENDER: begin
            code = sub_m[sub_addr_of(sx, sy)];
            base = ((code >> 1) % tmr_pkg::Tiles) * 64;
            for (int k = 0; k < 64; k++) begin
               col = (code & 1) ? 7 - (k % 8) : k % 8;
               p.color = pal_m[tile_m[base + (k / 8) * 8 + col]];
               p.last = (k == 63);
               pixels_due.push_back(p);
            end
         end
         tmr_pkg::OP_AVG: begin
            n = (block_cfg == 0) ? 1 : block_cfg;
            rs = 0; gs = 0; bs = 0;
            for (int i = 0; i < n; i++)
               for (int j = 0; j < n; j++) begin
                  base = tile_of(sx + j, sy + i);
                  for (int m = 0; m < 64; m++) begin
                     c = pal_m[tile_m[base + m]];
                     rs += c[23:16]; gs += c[15:8]; bs += c[7:0];
                  end
               end
            rs /= n * n * 64; gs /= n * n * 64; bs /= n * n * 64;
            p.color = {rs[7:0], gs[7:0], bs[7:0]};
            p.last = 1'b1;
            pixels_due.push_back(p);
         end
         default: ;
      endcase
   endfunction

   // call just after a rising edge; returns at the edge that takes the word
   task automatic send_word(tmr_pkg::op_type op, logic [20:0] a, logic [23:0] d,
                            logic [9:0] sx, logic [9:0] sy);
      bit free;
      if (idle_on && $urandom_range(0, 99) < 6) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      start <= 1'b1;
      req_operation <= op;
      req_table_address <= a;
      req_table_data <= d;
      req_sub_x <= sx;
      req_sub_y <= sy;
      do begin
         @(negedge clock) free = !busy;
         @(posedge clock);
      end while (!free);
      predict(op, a, d, sx, sy);
   endtask

   function automatic logic [15:0] pick_code();
      int unsigned keys [$];
      foreach (tile_pool[t]) keys.push_back(t);
      if (keys.size() > 0 && $urandom_range(0, 3) != 0)
         return {keys[$urandom_range(0, keys.size() - 1)][14:0], 1'($urandom)};
      return 16'($urandom);
   endfunction

   // write every entry on the lookup path of one subtile that is still blank
   task automatic fill_path(int unsigned x, int unsigned y);
      int unsigned cell_idx, g, mt, sa, t;
      cell_idx = cell_of(x, y);
      if (!map_m.exists(cell_idx))
         send_word(tmr_pkg::OP_MAP, cell_idx, $urandom, $urandom, $urandom);
      g = map_m[cell_idx] % tmr_pkg::GroupEntries;
      if (!grp_m.exists(g)) send_word(tmr_pkg::OP_GROUP, g, $urandom, $urandom, $urandom);
      mt = grp_m[g] % tmr_pkg::Megatiles;
      sa = mt * 16 + (x & 3) * 4 + (y & 3);
      if (!sub_m.exists(sa)) send_word(tmr_pkg::OP_SUB, sa, pick_code(), $urandom, $urandom);
      t = (sub_m[sa] >> 1) % tmr_pkg::Tiles;
      if (!tile_pool.exists(t)) begin
         tile_pool[t] = 1'b1;
         for (int m = 0; m < 64; m++)
            send_word(tmr_pkg::OP_TILE, t * 64 + m, $urandom, $urandom, $urandom);
      end
   endtask

   task automatic render_at(logic [9:0] x, logic [9:0] y);
      fill_path(x, y);
      send_word(tmr_pkg::OP_RENDER, $urandom, $urandom, x, y);
   endtask

   task automatic average_at(logic [9:0] x, logic [9:0] y);
      int unsigned n;
      n = (block_cfg == 0) ? 1 : block_cfg;
      for (int i = 0; i < n; i++)
         for (int j = 0; j < n; j++)
            fill_path(int'(x) + j, int'(y) + i);
      send_word(tmr_pkg::OP_AVG, $urandom, $urandom, x, y);
   endtask

   // hold off until every pixel is out and the queue has drained
   task automatic drain();
      start <= 1'b0;
      while (pixels_due.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic csr_write(logic [1:0] idx, logic [8:0] d);
      bit ok;
      drain();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= d;
      do begin
         @(negedge clock) ok = csr_ready;
         @(posedge clock);
      end while (!ok);
      csr_valid <= 1'b0;
      case (idx)
         tmr_pkg::CSR_WIDTH:  width_cfg = d;
         tmr_pkg::CSR_HEIGHT: height_cfg = d;
         tmr_pkg::CSR_BLOCK:  block_cfg = d[5:0];
         default: ;
      endcase
   endtask

   task automatic test_palette();
      send_word(tmr_pkg::OP_PAL, 0, 24'h000000, 0, 0);
      send_word(tmr_pkg::OP_PAL, 255, 24'hFFFFFF, 10'h3FF, 10'h3FF);
      for (int i = 1; i < 255; i++)
         send_word(tmr_pkg::OP_PAL, i, $urandom, $urandom, $urandom);
   endtask

   task automatic test_mirror();
      // one megatile with a plain and a mirrored subtile of the same tile
      send_word(tmr_pkg::OP_MAP, 0, 16'hFFFF, 0, 0);
      send_word(tmr_pkg::OP_GROUP, 16'hFFFF % tmr_pkg::GroupEntries, 16'hFFFF, 0, 0);
      send_word(tmr_pkg::OP_SUB, (16'hFFFF % tmr_pkg::Megatiles) * 16, 16'd6, 0, 0);
      send_word(tmr_pkg::OP_SUB, (16'hFFFF % tmr_pkg::Megatiles) * 16 + 4, 16'd7, 0, 0);
      render_at(0, 0);
      render_at(1, 0);
      render_at(10'h3FF, 10'h3FF);
   endtask

   task automatic test_ignored();
      send_word(tmr_pkg::OP_MAP, 21'h1FFFFF, 24'hFFFFFF, 0, 0);
      send_word(tmr_pkg::OP_GROUP, tmr_pkg::GroupEntries, 24'hFFFFFF, 0, 0);
      send_word(tmr_pkg::OP_SUB, tmr_pkg::Megatiles * 16, 24'hFFFFFF, 0, 0);
      send_word(tmr_pkg::OP_PAL, 256, 24'hFFFFFF, 0, 0);
      send_word(tmr_pkg::OP_NONE, $urandom, $urandom, $urandom, $urandom);
      csr_write(CsrSpare, 9'h1FF);
      render_at(0, 0);
   endtask

   task automatic test_width();
      csr_write(tmr_pkg::CSR_WIDTH, 0);
      render_at(10'd800, 10'd900);
      csr_write(tmr_pkg::CSR_WIDTH, 9'h1FF);
      csr_write(tmr_pkg::CSR_HEIGHT, 9'h1FF);
      render_at(10'h3FF, 10'h3FF);
      csr_write(tmr_pkg::CSR_WIDTH, 1);
      csr_write(tmr_pkg::CSR_HEIGHT, 1);
      render_at(10'd17, 10'd5);
      csr_write(tmr_pkg::CSR_WIDTH, 256);
      csr_write(tmr_pkg::CSR_HEIGHT, 256);
      render_at(10'h3FF, 10'd0);
   endtask

   task automatic test_average();
      csr_write(tmr_pkg::CSR_BLOCK, 0);
      average_at(0, 0);
      csr_write(tmr_pkg::CSR_BLOCK, 1);
      average_at(10'h3FF, 10'h3FF);
      csr_write(tmr_pkg::CSR_BLOCK, 2);
      average_at(10'h3FF, 10'h3FE);
      csr_write(tmr_pkg::CSR_BLOCK, 32);
      average_at(10'h3F0, 10'h3F8);
      csr_write(tmr_pkg::CSR_BLOCK, 9'h3F & 9'd3);
      average_at(10'd5, 10'd9);
   endtask

   task automatic test_random();
      int unsigned pick;
      for (int k = 0; k < 280; k++) begin
         idle_on = !(k >= 100 && k < 160);
         if (k % 40 == 39) begin
            pick = $urandom_range(0, 5);
            csr_write(tmr_pkg::CSR_WIDTH,
                      pick == 0 ? 9'd0 : pick == 1 ? 9'h1FF : 9'($urandom_range(1, 256)));
            csr_write(tmr_pkg::CSR_HEIGHT, $urandom);
            csr_write(tmr_pkg::CSR_BLOCK, 9'($urandom_range(0, 4)));
         end
         pick = $urandom_range(0, 99);
         if (pick < 55) render_at($urandom, $urandom);
         else if (pick < 75) average_at($urandom, $urandom);
         else if (pick < 97)
            send_word(tmr_pkg::op_type'($urandom_range(0, 4)), $urandom, $urandom,
                      $urandom, $urandom);
         else send_word(tmr_pkg::OP_NONE, $urandom, $urandom, $urandom, $urandom);
      end
      idle_on = 1'b1;
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_palette();
      test_mirror();
      test_ignored();
      test_width();
      test_average();
      test_random();
      drain();
      repeat (200) @(posedge clock);
      if (errors == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end
endmodule
